// ===== hw/rtl/grib2_message_structure_check_unit_macros.svh =====
// Assertion helper macros for the message structure checker.
`ifndef GRIB2_MESSAGE_STRUCTURE_CHECK_UNIT_MACROS_SVH
`define GRIB2_MESSAGE_STRUCTURE_CHECK_UNIT_MACROS_SVH
// Implication checked every clock outside reset.
`define G2C_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define G2C_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/g2chk_pkg.sv =====
// ----------------------------------------------------------------------------
// g2chk_pkg
// Shared types and constants of the message structure checker.
// ----------------------------------------------------------------------------
package g2chk_pkg;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NO_MARK   = 4'd1;
  localparam logic [3:0] ST_EDITION   = 4'd2;
  localparam logic [3:0] ST_NO_SEC1   = 4'd3;
  localparam logic [3:0] ST_EARLY_END = 4'd4;
  localparam logic [3:0] ST_NO_END    = 4'd5;
  localparam logic [3:0] ST_BAD_NUM   = 4'd6;
  localparam logic [3:0] ST_BAD_LEN   = 4'd7;
  localparam logic [3:0] ST_CORRUPT   = 4'd8;

  // parse phases
  localparam logic [2:0] PH_SEARCH  = 3'd0;
  localparam logic [2:0] PH_SEC0    = 3'd1;
  localparam logic [2:0] PH_SEC1LEN = 3'd2;
  localparam logic [2:0] PH_SEC1NUM = 3'd3;
  localparam logic [2:0] PH_WALKHDR = 3'd4;
  localparam logic [2:0] PH_WALKNUM = 3'd5;
  localparam logic [2:0] PH_DONE    = 3'd6;

  localparam logic [31:0] END_MARK = 32'h3737_3737;

  // one registered input byte
  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] len;
    logic        last;
    logic [31:0] pos;
  } byte_t;

  // verdict plus decoded fields
  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  discipline;
    logic [7:0]  edition;
    logic [31:0] message_length;
    logic [15:0] field_count;
    logic [15:0] local_count;
    logic [15:0] centre_id;
    logic [15:0] subcentre_id;
    logic [15:0] table_versions;
    logic [7:0]  time_significance;
    logic [55:0] reference_time;
    logic [15:0] production_info;
  } verdict_t;

endpackage

// ===== hw/rtl/g2chk_parser.sv =====
// ----------------------------------------------------------------------------
// g2chk_parser
// Per-byte section walker; produces one verdict on the last byte.
// ----------------------------------------------------------------------------
module g2chk_parser #(
  parameter int SearchWindow = 100,
  parameter int CountBits    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  g2chk_pkg::byte_t   byte_i,
  output logic               done_o,
  output g2chk_pkg::verdict_t verdict_o
);
  import g2chk_pkg::*;

  localparam logic [CountBits-1:0] CntMax = {CountBits{1'b1}};
  localparam logic [31:0] WinLim = 32'(SearchWindow);

  logic [2:0]   phase_q, phase_d;
  logic [6:0]   start_q, start_d;
  logic [31:0]  sbeg_q, sbeg_d, ssize_q, ssize_d, word_q, word_d;
  logic [23:0]  hist_q, hist_d;
  logic [CountBits-1:0] fields_q, fields_d, locals_q, locals_d;
  logic [63:0]  id0_q, id0_d, id1_q, id1_d, id2_q, id2_d;
  logic         given_q, given_d, mark_q, mark_d, ident_q, ident_d;
  logic [3:0]   code_q, code_d;

  logic [7:0]   b;
  logic [31:0]  p, sz, off, rem0, asm, nb, srem;
  logic [3:0]   k;
  logic [5:0]   sh;

  assign b  = byte_i.data;
  assign p  = byte_i.pos;
  assign sz = byte_i.len;
  assign off  = p - {25'd0, start_q};
  assign rem0 = sz - {25'd0, start_q};
  assign asm  = {word_q[23:0], b};
  assign k  = 4'(off - 32'd21);
  assign sh = {~k[2:0], 3'b000};

  always_comb begin
    phase_d = phase_q; start_d = start_q; sbeg_d = sbeg_q; ssize_d = ssize_q;
    word_d = word_q; hist_d = hist_q; fields_d = fields_q; locals_d = locals_q;
    id0_d = id0_q; id1_d = id1_q; id2_d = id2_q; given_d = given_q;
    mark_d = mark_q; ident_d = ident_q; code_d = code_q;
    nb = 32'd0; srem = 32'd0;
    if (take_i && (p < sz)) begin
      if (mark_q) begin
        if (off == 32'd6) id2_d[47:40] = b;
        else if (off == 32'd7) id2_d[39:32] = b;
        else if (off >= 32'd12 && off <= 32'd15)
          id2_d = id2_q | ({56'd0, b} << {~off[1:0], 3'b000});
        else if (ident_q && off >= 32'd21 && off <= 32'd36) begin
          if (k[3]) id1_d = id1_q | ({56'd0, b} << sh);
          else id0_d = id0_q | ({56'd0, b} << sh);
        end
      end
      if (!given_q) begin
        case (phase_q)
          PH_SEARCH: begin
            hist_d = {hist_q[15:0], b};
            if (p >= 32'd3 && (p - 32'd3) < WinLim && {hist_q, b} == "GRIB") begin
              start_d = 7'(p - 32'd3);
              mark_d = 1'b1;
              phase_d = PH_SEC0;
              if ((sz - (p - 32'd3)) < 32'd16) begin
                given_d = 1'b1; code_d = ST_CORRUPT; phase_d = PH_DONE;
              end
            end else if (p >= WinLim + 32'd2 || p + 32'd1 >= sz) begin
              given_d = 1'b1; code_d = ST_NO_MARK; phase_d = PH_DONE;
            end
          end
          PH_SEC0: begin
            if (off == 32'd15) begin
              if ({id2_q[31:8], b} > rem0) begin
                given_d = 1'b1; code_d = ST_BAD_LEN; phase_d = PH_DONE;
              end else if (id2_q[39:32] != 8'd2) begin
                given_d = 1'b1; code_d = ST_EDITION; phase_d = PH_DONE;
              end else if (rem0 - 32'd16 < 32'd4) begin
                given_d = 1'b1; code_d = ST_CORRUPT; phase_d = PH_DONE;
              end else begin
                phase_d = PH_SEC1LEN; word_d = 32'd0;
              end
            end
          end
          PH_SEC1LEN: begin
            word_d = asm;
            if (off == 32'd19) begin
              if (asm < 32'd16 || asm > rem0 - 32'd16) begin
                given_d = 1'b1; code_d = ST_BAD_LEN; phase_d = PH_DONE;
              end else begin
                ssize_d = asm; phase_d = PH_SEC1NUM;
              end
            end
          end
          PH_SEC1NUM: begin
            if (b != 8'd1) begin
              given_d = 1'b1; code_d = ST_NO_SEC1; phase_d = PH_DONE;
            end else begin
              ident_d = 1'b1;
              if (rem0 < 32'd37) begin
                given_d = 1'b1; code_d = ST_CORRUPT; phase_d = PH_DONE;
              end else begin
                nb = {25'd0, start_q} + 32'd16 + ssize_q;
                srem = sz - nb;
                sbeg_d = nb; word_d = 32'd0;
                if (srem < 32'd4) begin
                  given_d = 1'b1; phase_d = PH_DONE;
                  code_d = (srem == 32'd0) ? ST_OK : ST_NO_END;
                end else phase_d = PH_WALKHDR;
              end
            end
          end
          PH_WALKHDR: begin
            if (p >= sbeg_q) begin
              word_d = asm;
              if (p - sbeg_q == 32'd3) begin
                srem = sz - sbeg_q;
                if (asm == END_MARK) begin
                  given_d = 1'b1; phase_d = PH_DONE;
                  code_d = (srem == 32'd4) ? ST_OK : ST_EARLY_END;
                end else if (asm < 32'd5 || asm > srem) begin
                  given_d = 1'b1; code_d = ST_BAD_LEN; phase_d = PH_DONE;
                end else begin
                  ssize_d = asm; phase_d = PH_WALKNUM;
                end
              end
            end
          end
          PH_WALKNUM: begin
            if (b < 8'd2 || b > 8'd7) begin
              given_d = 1'b1; code_d = ST_BAD_NUM; phase_d = PH_DONE;
            end else begin
              if (b == 8'd2 && locals_q != CntMax) locals_d = locals_q + 1'b1;
              if (b == 8'd4 && fields_q != CntMax) fields_d = fields_q + 1'b1;
              nb = sbeg_q + ssize_q;
              srem = sz - nb;
              sbeg_d = nb; word_d = 32'd0;
              if (srem < 32'd4) begin
                given_d = 1'b1; phase_d = PH_DONE;
                code_d = (srem == 32'd0) ? ST_OK : ST_NO_END;
              end else phase_d = PH_WALKHDR;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result assembled from next-state values
  always_comb begin
    verdict_o.status = given_d ? code_d : ((phase_d == PH_SEARCH) ? ST_NO_MARK : ST_CORRUPT);
    verdict_o.discipline        = id2_d[47:40];
    verdict_o.edition           = id2_d[39:32];
    verdict_o.message_length    = id2_d[31:0];
    verdict_o.field_count       = 16'(fields_d);
    verdict_o.local_count       = 16'(locals_d);
    verdict_o.centre_id         = id0_d[63:48];
    verdict_o.subcentre_id      = id0_d[47:32];
    verdict_o.table_versions    = id0_d[31:16];
    verdict_o.time_significance = id0_d[15:8];
    verdict_o.reference_time    = {id0_d[7:0], id1_d[63:16]};
    verdict_o.production_info   = id1_d[15:0];
  end
  assign done_o = take_i && byte_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH; start_q <= '0; sbeg_q <= '0; ssize_q <= '0;
      word_q <= '0; hist_q <= '0; fields_q <= '0; locals_q <= '0;
      id0_q <= '0; id1_q <= '0; id2_q <= '0; given_q <= 1'b0;
      mark_q <= 1'b0; ident_q <= 1'b0; code_q <= ST_OK;
    end else if (take_i && byte_i.last) begin
      phase_q <= PH_SEARCH; start_q <= '0; sbeg_q <= '0; ssize_q <= '0;
      word_q <= '0; hist_q <= '0; fields_q <= '0; locals_q <= '0;
      id0_q <= '0; id1_q <= '0; id2_q <= '0; given_q <= 1'b0;
      mark_q <= 1'b0; ident_q <= 1'b0; code_q <= ST_OK;
    end else begin
      phase_q <= phase_d; start_q <= start_d; sbeg_q <= sbeg_d; ssize_q <= ssize_d;
      word_q <= word_d; hist_q <= hist_d; fields_q <= fields_d; locals_q <= locals_d;
      id0_q <= id0_d; id1_q <= id1_d; id2_q <= id2_d; given_q <= given_d;
      mark_q <= mark_d; ident_q <= ident_d; code_q <= code_d;
    end
  end

endmodule

// ===== hw/rtl/grib2_message_structure_check_unit.sv =====
// The last byte goes to the input register; its verdict is then registered.
// Throughput: one byte per cycle unless in_stall_o; an input register and a
// result register with a skid slot let input run while a verdict waits for the consumer.
// Byte position counts transfers and saturates at 2^32-1.
// Reset (rst_ni low, asynchronous) clears all parse state and empties output.
// After each verdict all parse state returns to reset for the next buffer.
// ----------------------------------------------------------------------------
// grib2_message_structure_check_unit
// Byte-stream checker of message sections; one verdict per buffer.
// ----------------------------------------------------------------------------
module grib2_message_structure_check_unit #(
  parameter int SearchWindow = 100,
  parameter int CountBits    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] buffer_length_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [7:0]  discipline_o,
  output logic [7:0]  edition_o,
  output logic [31:0] message_length_o,
  output logic [15:0] field_count_o,
  output logic [15:0] local_count_o,
  output logic [15:0] centre_id_o,
  output logic [15:0] subcentre_id_o,
  output logic [15:0] table_versions_o,
  output logic [7:0]  time_significance_o,
  output logic [55:0] reference_time_o,
  output logic [15:0] production_info_o
);
  import g2chk_pkg::*;

  // Input register stage.
  logic   in_v_q;
  byte_t  in_q;
  logic [31:0] pos_q;
  logic   take;
  logic   done;
  verdict_t vd;

  // Output register plus one skid slot. Input stalls while the skid slot is
  // occupied or is being filled this cycle, so a verdict waiting alone in the
  // output register never blocks bytes that make none and no verdict is overwritten.
  logic     out_v_q, skid_v_q;
  verdict_t out_q, skid_q;

  assign in_stall_o = skid_v_q || (done && out_v_q && out_stall_i);
  assign take = in_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      in_v_q <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        if (last_byte_i) pos_q <= '0;
        else if (pos_q != 32'hFFFF_FFFF) pos_q <= pos_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q.data <= data_byte_i;
      in_q.len  <= buffer_length_i;
      in_q.last <= last_byte_i;
      in_q.pos  <= pos_q;
    end
  end

  g2chk_parser #(
    .SearchWindow(SearchWindow),
    .CountBits   (CountBits)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .byte_i   (in_q),
    .done_o   (done),
    .verdict_o(vd)
  );

  // A verdict can land while output is full only if the skid slot is free,
  // which the input stall guarantees (at most one byte in flight).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || !out_stall_i) begin
        out_v_q  <= skid_v_q || done;
        skid_v_q <= skid_v_q && done;
      end else if (done) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_q <= skid_q;
        if (done) skid_q <= vd;
      end else if (done) out_q <= vd;
    end else if (done) skid_q <= vd;
  end

  assign out_valid_o         = out_v_q;
  assign status_o            = out_q.status;
  assign discipline_o        = out_q.discipline;
  assign edition_o           = out_q.edition;
  assign message_length_o    = out_q.message_length;
  assign field_count_o       = out_q.field_count;
  assign local_count_o       = out_q.local_count;
  assign centre_id_o         = out_q.centre_id;
  assign subcentre_id_o      = out_q.subcentre_id;
  assign table_versions_o    = out_q.table_versions;
  assign time_significance_o = out_q.time_significance;
  assign reference_time_o    = out_q.reference_time;
  assign production_info_o   = out_q.production_info;

endmodule

// ===== hw/rtl/g2chk_checker.sv =====
// ----------------------------------------------------------------------------
// g2chk_checker
// Port-level checks of the message structure checker.
// ----------------------------------------------------------------------------
`include "grib2_message_structure_check_unit_macros.svh"
module g2chk_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] status_o
);
  `G2C_ASSERT_IMP(a_status_range, clk_i, rst_ni, out_valid_o, status_o <= 4'd8, "status out of range")
  `G2C_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o), "stalled verdict changed")
  `G2C_ASSERT_NXT(a_no_spurious, clk_i, rst_ni, !out_valid_o && !$past(in_valid_i && !in_stall_o && last_byte_i), !out_valid_o, "verdict without last byte")
  `G2C_ASSERT_NXT(a_stall_frees, clk_i, rst_ni, in_stall_o && !out_stall_i, !in_stall_o, "input stall did not release")
endmodule

bind grib2_message_structure_check_unit g2chk_checker u_g2chk_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .last_byte_i(last_byte_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o   (status_o)
);
